// ----- rtl/i2c_master_register_access_defines.svh -----
// Assertion macros for the I2C master register access block.
// Relies on clk and arst_n being visible in the including module.
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

// Flag a condition that must never hold out of reset.
`define I2CM_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// Flag a broken same-cycle implication.
`define I2CM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Flag a broken next-cycle implication.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/i2cm_pkg.sv -----
// Shared types and codes for the I2C master register access block.
// No dependencies; imported by the front, back and top level.
`timescale 1ns / 1ps

package i2cm_pkg;

	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_BURST = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BUSY  = 2'd1;
	localparam logic [1:0] ST_FAULT = 2'd2;
	localparam logic [1:0] ST_NACK  = 2'd3;

	localparam logic [7:0] QUARTER_RESET = 8'd30;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] device_byte;
		logic [7:0] register_byte;
		logic [7:0] write_data;
		logic [7:0] byte_count;
		logic       sda_in;
	} in_word_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       byte_valid;
		logic [7:0] read_byte;
		logic       done_res;
		logic [1:0] status;
	} out_word_t;

	typedef struct packed {
		logic valid;
		logic has_cmd;
	} fe_ctrl_t;

endpackage

// ----- rtl/i2c_master_register_access.sv -----
// I2C master register access top level: front queue, phase sequencer, result queue.
// A pushed word waits in the front queue and is stepped into the result queue to be popped.
// Throughput: one tick word per cycle when the result queue has room, set by the sequencer.
// Reset (arst_n low, asynchronous): both queues empty, bus lines released, sequencer idle,
// quarter period back to 30 ticks. Configuration writes are taken every cycle.
`timescale 1ns / 1ps

module i2c_master_register_access (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  i2cm_pkg::in_word_t  in_word,
	output logic                empty,
	input  logic                pop,
	output i2cm_pkg::out_word_t out_word,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);
	import i2cm_pkg::*;

	in_word_t head_word;
	fe_ctrl_t head_ctrl;
	logic     adv;

	assign cfg_ready = 1'b1;

	i2cm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_word   (in_word),
		.adv       (adv),
		.head_word (head_word),
		.head_ctrl (head_ctrl)
	);

	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.head_word (head_word),
		.head_ctrl (head_ctrl),
		.adv       (adv),
		.empty     (empty),
		.pop       (pop),
		.out_word  (out_word)
	);

endmodule

// ----- rtl/i2cm_front.sv -----
// Front end: two-word input queue that tags each tick with whether it carries a command.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  i2cm_pkg::in_word_t in_word,
	input  logic               adv,
	output i2cm_pkg::in_word_t head_word,
	output i2cm_pkg::fe_ctrl_t head_ctrl
);
	import i2cm_pkg::*;

	in_word_t   mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       put;
	logic       take;

	assign full = (cnt_q == 2'd2);
	assign put  = push && !full;
	assign take = adv && (cnt_q != 2'd0);

	assign head_word = mem_q[rd_q];
	assign head_ctrl = {(cnt_q != 2'd0), (mem_q[rd_q].op != OP_NONE)};

	always_ff @(posedge clk) begin
		if (put) begin
			mem_q[wr_q] <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (put) begin
				wr_q <= ~wr_q;
			end
			if (take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, put} - {1'b0, take};
		end
	end

endmodule

// ----- rtl/i2cm_back.sv -----
// Back end: bus phase sequencer stepping one tick per word, plus a two-word result queue.
// Depends on i2cm_pkg and the assertion macro header.
`timescale 1ns / 1ps

module i2cm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [7:0]          cfg_data,
	input  i2cm_pkg::in_word_t  head_word,
	input  i2cm_pkg::fe_ctrl_t  head_ctrl,
	output logic                adv,
	output logic                empty,
	input  logic                pop,
	output i2cm_pkg::out_word_t out_word
);
	import i2cm_pkg::*;
	`include "i2c_master_register_access_defines.svh"

	localparam logic [4:0] PH_IDLE = 5'd0;
	localparam logic [4:0] PH_ST_A = 5'd1;
	localparam logic [4:0] PH_ST_B = 5'd2;
	localparam logic [4:0] PH_ST_C = 5'd3;
	localparam logic [4:0] PH_TX_A = 5'd4;
	localparam logic [4:0] PH_TX_B = 5'd5;
	localparam logic [4:0] PH_TX_C = 5'd6;
	localparam logic [4:0] PH_WA_A = 5'd7;
	localparam logic [4:0] PH_WA_B = 5'd8;
	localparam logic [4:0] PH_WA_C = 5'd9;
	localparam logic [4:0] PH_WA_N = 5'd10;
	localparam logic [4:0] PH_RX_A = 5'd11;
	localparam logic [4:0] PH_RX_B = 5'd12;
	localparam logic [4:0] PH_AK_A = 5'd13;
	localparam logic [4:0] PH_AK_B = 5'd14;
	localparam logic [4:0] PH_AK_C = 5'd15;
	localparam logic [4:0] PH_AK_D = 5'd16;
	localparam logic [4:0] PH_SP_A = 5'd17;
	localparam logic [4:0] PH_SP_B = 5'd18;
	localparam logic [4:0] PH_SP_C = 5'd19;
	localparam logic [4:0] PH_SP_D = 5'd20;

	localparam logic [1:0] STAGE_DEV   = 2'd0;
	localparam logic [1:0] STAGE_REG   = 2'd1;
	localparam logic [1:0] STAGE_DATA  = 2'd2;
	localparam logic [1:0] STAGE_DEVRD = 2'd3;

	// Line levels on entry to a phase: bit 1 SDA, bit 0 SCL.
	function automatic logic [1:0] enter_lines(input logic [4:0] ph, input logic [1:0] cur,
			input logic bit_v, input logic ack);
		logic scl;
		logic sda;
		begin
			scl = 1'b0;
			sda = cur[1];
			case (ph) inside
				PH_ST_A: begin
					scl = 1'b1; sda = 1'b1;
				end
				PH_ST_B, PH_ST_C: begin
					scl = 1'b1; sda = 1'b0;
				end
				PH_TX_B: sda = bit_v;
				PH_TX_C: begin
					scl = 1'b1; sda = bit_v;
				end
				PH_WA_B, PH_WA_N, PH_RX_A: sda = 1'b1;
				PH_WA_C, PH_RX_B: begin
					scl = 1'b1; sda = 1'b1;
				end
				PH_AK_B, PH_AK_D: sda = ack;
				PH_AK_C: begin
					scl = 1'b1; sda = ack;
				end
				PH_SP_B: sda = 1'b0;
				PH_SP_C: begin
					scl = 1'b1; sda = 1'b0;
				end
				PH_SP_D: begin
					scl = 1'b1; sda = 1'b1;
				end
				default: scl = 1'b0;
			endcase
			enter_lines = {sda, scl};
		end
	endfunction

	logic [7:0] quarter_q;
	logic [4:0] phase_q;
	logic [7:0] tick_q;
	logic [3:0] bit_q;
	logic [7:0] shift_q;
	logic [7:0] left_q;
	logic [7:0] dev_q;
	logic [7:0] reg_q;
	logic [7:0] val_q;
	logic [1:0] cmd_q;
	logic [1:0] lines_q;
	logic [1:0] stage_q;
	logic [1:0] err_q;

	logic [4:0] n_phase;
	logic [7:0] n_tick;
	logic [3:0] n_bit;
	logic [7:0] n_shift;
	logic [7:0] n_left;
	logic [7:0] n_dev;
	logic [7:0] n_reg;
	logic [7:0] n_val;
	logic [1:0] n_cmd;
	logic [1:0] n_lines;
	logic [1:0] n_stage;
	logic [1:0] n_err;
	logic [7:0] q_eff;
	logic       ent;
	logic [4:0] ent_ph;
	out_word_t  res;

	out_word_t  omem_q [2];
	logic       owr_q;
	logic       ord_q;
	logic [1:0] ocnt_q;
	logic       otake;
	logic       room;

	assign otake    = pop && (ocnt_q != 2'd0);
	assign room     = (ocnt_q != 2'd2) || otake;
	assign adv      = head_ctrl.valid && room;
	assign empty    = (ocnt_q == 2'd0);
	assign out_word = omem_q[ord_q];

	always_comb begin
		n_phase = phase_q;
		n_tick  = tick_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_left  = left_q;
		n_dev   = dev_q;
		n_reg   = reg_q;
		n_val   = val_q;
		n_cmd   = cmd_q;
		n_lines = lines_q;
		n_stage = stage_q;
		n_err   = err_q;
		ent     = 1'b0;
		ent_ph  = PH_IDLE;
		res     = '0;
		q_eff   = (quarter_q == 8'd0) ? 8'd1 : quarter_q;

		if (phase_q == PH_IDLE && !head_ctrl.has_cmd) begin
			n_lines         = 2'b11;
			res.scl_release = 1'b1;
			res.sda_release = 1'b1;
		end else begin
			if (phase_q == PH_IDLE) begin
				n_cmd   = head_word.op;
				n_dev   = head_word.device_byte;
				n_reg   = head_word.register_byte;
				n_val   = head_word.write_data;
				n_left  = (head_word.op == OP_BURST) ? head_word.byte_count : 8'd1;
				if (n_left == 8'd0) begin
					n_left = 8'd1;
				end
				n_stage = STAGE_DEV;
				n_err   = ST_OK;
				n_phase = PH_ST_A;
				n_tick  = 8'd0;
				n_lines = enter_lines(PH_ST_A, n_lines, n_shift[7], !(n_left > 8'd1));
			end
			res.scl_release = n_lines[0];
			res.sda_release = n_lines[1];
			res.busy_res    = 1'b1;

			n_tick = n_tick + 8'd1;
			if (n_tick >= q_eff) begin
				n_tick = 8'd0;
				unique case (n_phase)
					PH_ST_A: begin
						if (n_stage == STAGE_DEV && !head_word.sda_in) begin
							res.done_res = 1'b1; res.status = ST_BUSY; n_phase = PH_IDLE;
						end else begin
							ent = 1'b1; ent_ph = PH_ST_B;
						end
					end
					PH_ST_B: begin
						if (n_stage == STAGE_DEV && head_word.sda_in) begin
							res.done_res = 1'b1; res.status = ST_FAULT; n_phase = PH_IDLE;
						end else begin
							ent = 1'b1; ent_ph = PH_ST_C;
						end
					end
					PH_ST_C: begin
						n_shift = (n_stage == STAGE_DEV) ? n_dev : n_dev + 8'd1;
						n_bit   = 4'd0;
						ent = 1'b1; ent_ph = PH_TX_A;
					end
					PH_TX_A: begin
						ent = 1'b1; ent_ph = PH_TX_B;
					end
					PH_TX_B: begin
						ent = 1'b1; ent_ph = PH_TX_C;
					end
					PH_TX_C: begin
						n_shift = {n_shift[6:0], 1'b0};
						n_bit   = n_bit + 4'd1;
						ent = 1'b1; ent_ph = (n_bit >= 4'd8) ? PH_WA_A : PH_TX_A;
					end
					PH_WA_A: begin
						ent = 1'b1; ent_ph = PH_WA_B;
					end
					PH_WA_B: begin
						ent = 1'b1; ent_ph = PH_WA_C;
					end
					PH_WA_C: begin
						ent = 1'b1;
						if (n_stage == STAGE_DEV) begin
							if (head_word.sda_in) begin
								n_err = ST_NACK; ent_ph = PH_WA_N;
							end else begin
								n_stage = STAGE_REG; n_shift = n_reg; n_bit = 4'd0;
								ent_ph = PH_TX_A;
							end
						end else if (n_stage == STAGE_REG) begin
							if (n_cmd == OP_WRITE) begin
								n_stage = STAGE_DATA; n_shift = n_val; n_bit = 4'd0;
								ent_ph = PH_TX_A;
							end else begin
								n_stage = STAGE_DEVRD; ent_ph = PH_ST_A;
							end
						end else if (n_stage == STAGE_DATA) begin
							ent_ph = PH_SP_A;
						end else begin
							n_shift = 8'd0; n_bit = 4'd0; ent_ph = PH_RX_A;
						end
					end
					PH_WA_N: begin
						ent = 1'b1; ent_ph = PH_SP_A;
					end
					PH_RX_A: begin
						ent = 1'b1; ent_ph = PH_RX_B;
					end
					PH_RX_B: begin
						n_shift = {n_shift[6:0], head_word.sda_in};
						n_bit   = n_bit + 4'd1;
						ent = 1'b1;
						if (n_bit >= 4'd8) begin
							res.byte_valid = 1'b1; res.read_byte = n_shift; ent_ph = PH_AK_A;
						end else begin
							ent_ph = PH_RX_A;
						end
					end
					PH_AK_A: begin
						ent = 1'b1; ent_ph = PH_AK_B;
					end
					PH_AK_B: begin
						ent = 1'b1; ent_ph = PH_AK_C;
					end
					PH_AK_C: begin
						ent = 1'b1; ent_ph = PH_AK_D;
					end
					PH_AK_D: begin
						ent = 1'b1;
						if (n_left > 8'd1) begin
							n_left = n_left - 8'd1;
							n_shift = 8'd0; n_bit = 4'd0; ent_ph = PH_RX_A;
						end else begin
							ent_ph = PH_SP_A;
						end
					end
					PH_SP_A: begin
						ent = 1'b1; ent_ph = PH_SP_B;
					end
					PH_SP_B: begin
						ent = 1'b1; ent_ph = PH_SP_C;
					end
					PH_SP_C: begin
						ent = 1'b1; ent_ph = PH_SP_D;
					end
					PH_SP_D: begin
						res.done_res = 1'b1; res.status = n_err; n_phase = PH_IDLE;
					end
					default: n_phase = PH_IDLE;
				endcase
				if (ent) begin
					n_phase = ent_ph;
					n_tick  = 8'd0;
					n_lines = enter_lines(ent_ph, n_lines, n_shift[7], !(n_left > 8'd1));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quarter_q <= QUARTER_RESET;
			phase_q   <= PH_IDLE;
			tick_q    <= 8'd0;
			bit_q     <= 4'd0;
			shift_q   <= 8'd0;
			left_q    <= 8'd0;
			dev_q     <= 8'd0;
			reg_q     <= 8'd0;
			val_q     <= 8'd0;
			cmd_q     <= OP_NONE;
			lines_q   <= 2'b11;
			stage_q   <= STAGE_DEV;
			err_q     <= ST_OK;
		end else begin
			if (cfg_valid) begin
				quarter_q <= cfg_data;
			end
			if (adv) begin
				phase_q <= n_phase;
				tick_q  <= n_tick;
				bit_q   <= n_bit;
				shift_q <= n_shift;
				left_q  <= n_left;
				dev_q   <= n_dev;
				reg_q   <= n_reg;
				val_q   <= n_val;
				cmd_q   <= n_cmd;
				lines_q <= n_lines;
				stage_q <= n_stage;
				err_q   <= n_err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			omem_q[owr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (adv) begin
				owr_q <= ~owr_q;
			end
			if (otake) begin
				ord_q <= ~ord_q;
			end
			ocnt_q <= ocnt_q + {1'b0, adv} - {1'b0, otake};
		end
	end

	`I2CM_ASSERT_NEVER(a_ocnt_range, ocnt_q == 2'd3, "result queue count out of range")
	`I2CM_ASSERT_IMPL(a_no_overrun, (ocnt_q == 2'd2) && !pop, !adv, "tick stepped into full queue")
	`I2CM_ASSERT_NEXT(a_result_held, adv, ocnt_q != 2'd0, "stepped tick left no result")
	`I2CM_ASSERT_NEVER(a_phase_range, phase_q > PH_SP_D, "sequencer phase out of range")

endmodule
